// ----- hdl/sapt_pkg.sv -----
package sapt_pkg;

    localparam int SETS_DEF       = 1024;
    localparam int WAYS_DEF       = 4;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int AGE_WIDTH_DEF  = 8;

    localparam int ADDR_FIELD_W = 32;
    localparam int DATA_FIELD_W = 16;
    localparam int OP_W         = 2;

    localparam int LFSR_W = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL    = 2'd2;

    localparam int POLICY_W = 2;
    localparam logic [POLICY_W-1:0] POL_WAY0   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd2;

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_LSB  = 2;
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_TAGLESS = 1'b1;

    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic                tagless;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic commit;
        logic sweep_we;
        logic sweep_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic in_fill;
        logic out_free;
        logic sweep_last;
    } t_dp_status;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// ----- hdl/sapt_ram.sv -----
module sapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sapt_regs.sv -----
module sapt_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sapt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sapt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sapt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output sapt_pkg::t_cfg                    o_cfg
);

    sapt_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic           reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[sapt_pkg::CFG_IDX_LSB];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sapt_pkg::REG_POLICY: begin
                    r_cfg.policy <= pwdata[sapt_pkg::POLICY_W-1:0];
                end
                sapt_pkg::REG_TAGLESS: begin
                    r_cfg.tagless <= pwdata[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            sapt_pkg::REG_POLICY: begin
                prdata = sapt_pkg::CFG_DATA_W'(r_cfg.policy);
            end
            sapt_pkg::REG_TAGLESS: begin
                prdata = sapt_pkg::CFG_DATA_W'(r_cfg.tagless);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/sapt_ctrl.sv -----
module sapt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sapt_pkg::t_dp_status  i_status,
    output sapt_pkg::t_dp_cmd     o_cmd,
    output logic                  o_ready
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_FILL  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_we   = 1'b1;
                o_cmd.sweep_zero = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_status.in_fill ? S_FILL : S_EVAL;
                end
            end
            S_FILL: begin
                o_cmd.sweep_we = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_ends_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_status.sweep_last) |=> (r_state == S_EVAL))
        else $error("Fill sweep did not hand over to the result stage.");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_ready)
        else $error("A second item could be taken while one is in work.");
`endif

endmodule

// ----- hdl/sapt_dp.sv -----
module sapt_dp #(
    parameter int SETS       = sapt_pkg::SETS_DEF,
    parameter int WAYS       = sapt_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH = sapt_pkg::ADDR_WIDTH_DEF,
    parameter int DATA_WIDTH = sapt_pkg::DATA_WIDTH_DEF,
    parameter int AGE_WIDTH  = sapt_pkg::AGE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sapt_pkg::t_dp_cmd                    i_cmd,
    output sapt_pkg::t_dp_status                 o_status,
    input  sapt_pkg::t_cfg                       i_cfg,
    input  logic [sapt_pkg::OP_W-1:0]            i_op,
    input  logic [sapt_pkg::ADDR_FIELD_W-1:0]    i_address,
    input  logic [sapt_pkg::DATA_FIELD_W-1:0]    i_entry_data,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [sapt_pkg::DATA_FIELD_W-1:0]    o_data,
    output logic                                 o_hit
);

    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int ROWS     = 1 << SET_BITS;
    localparam int EFF_ADDR = (ADDR_WIDTH < sapt_pkg::ADDR_FIELD_W) ?
                              ADDR_WIDTH : sapt_pkg::ADDR_FIELD_W;
    localparam int TAG_W    = EFF_ADDR - SET_BITS;
    localparam int DW       = (DATA_WIDTH < sapt_pkg::DATA_FIELD_W) ?
                              DATA_WIDTH : sapt_pkg::DATA_FIELD_W;
    localparam int ENTRY_W  = TAG_W + DW + AGE_WIDTH;
    localparam int ROW_W    = WAYS * ENTRY_W;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LW       = sapt_pkg::LFSR_W;
    localparam int RCP_SHIFT = LW + $clog2(WAYS);
    localparam int PROD_W    = RCP_SHIFT + LW;
    localparam longint RCP_MUL = ((longint'(1) << RCP_SHIFT) + WAYS - 1) / WAYS;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

    logic [sapt_pkg::OP_W-1:0] r_op;
    logic [SET_BITS-1:0]       r_set;
    logic [TAG_W-1:0]          r_tag;
    logic [DW-1:0]             r_wdata;
    logic [LW-1:0]             r_lfsr;
    logic [LW-1:0]             r_q;
    logic [SET_BITS-1:0]       r_sweep_idx;
    logic                      r_out_valid;
    logic [sapt_pkg::DATA_FIELD_W-1:0] r_out_data;
    logic                      r_out_hit;

    logic [LW-1:0]     lfsr_next;
    logic [PROD_W-1:0] rcp_prod;
    logic [LW-1:0]     rnd_rem;
    logic [WAY_W-1:0]  way_rnd;

    logic              ram_we;
    logic [SET_BITS-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;

    logic [TAG_W-1:0]     way_tag  [WAYS];
    logic [DW-1:0]        way_data [WAYS];
    logic [AGE_WIDTH-1:0] way_age  [WAYS];

    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [ROW_W-1:0] new_row;
    logic [ROW_W-1:0] sweep_row;
    logic             row_we;
    logic [sapt_pkg::DATA_FIELD_W-1:0] eval_data;
    logic             eval_hit;

    function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] a);
        return (a == AGE_MAX) ? a : a + AGE_WIDTH'(1);
    endfunction

    // The way for a random replace is the stepped LFSR modulo WAYS, worked out
    // as a reciprocal multiply at accept and a back-multiply in the next cycle.
    assign lfsr_next = sapt_pkg::lfsr_step(r_lfsr);
    assign rcp_prod  = PROD_W'(lfsr_next) * PROD_W'(RCP_MUL);
    assign rnd_rem   = r_lfsr - LW'(r_q * LW'(WAYS));
    assign way_rnd   = rnd_rem[WAY_W-1:0];

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            way_age[w]  = ram_rdata[w*ENTRY_W +: AGE_WIDTH];
            way_data[w] = ram_rdata[w*ENTRY_W + AGE_WIDTH +: DW];
            way_tag[w]  = ram_rdata[w*ENTRY_W + AGE_WIDTH + DW +: TAG_W];
        end
    end

    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_tag[w] == r_tag) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end
    end

    always_comb begin
        victim = '0;
        for (int w = 1; w < WAYS; w++) begin
            if (way_age[victim] < way_age[w]) begin
                victim = WAY_W'(w);
            end
        end
    end

    always_comb begin
        new_row   = ram_rdata;
        row_we    = 1'b0;
        eval_data = '0;
        eval_hit  = 1'b0;
        if (r_op == sapt_pkg::OP_LOOKUP) begin
            if (i_cfg.tagless) begin
                eval_data = sapt_pkg::DATA_FIELD_W'(way_data[0]);
                eval_hit  = 1'b1;
            end else begin
                if (hit_found) begin
                    eval_data = sapt_pkg::DATA_FIELD_W'(way_data[hit_way]);
                    eval_hit  = 1'b1;
                end
                if (i_cfg.policy == sapt_pkg::POL_LRU) begin
                    row_we = 1'b1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_found && WAY_W'(w) == hit_way) begin
                            new_row[w*ENTRY_W +: AGE_WIDTH] = '0;
                        end else if (!hit_found || WAY_W'(w) < hit_way) begin
                            new_row[w*ENTRY_W +: AGE_WIDTH] = age_inc(way_age[w]);
                        end
                    end
                end
            end
        end else if (r_op == sapt_pkg::OP_REPLACE) begin
            row_we = 1'b1;
            if (i_cfg.policy == sapt_pkg::POL_LRU) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (WAY_W'(w) == victim) begin
                        new_row[w*ENTRY_W +: ENTRY_W] = {r_tag, r_wdata, AGE_WIDTH'(0)};
                    end else begin
                        new_row[w*ENTRY_W +: AGE_WIDTH] = age_inc(way_age[w]);
                    end
                end
            end else if (i_cfg.policy == sapt_pkg::POL_RANDOM) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (WAY_W'(w) == way_rnd) begin
                        new_row[w*ENTRY_W + AGE_WIDTH +: DW + TAG_W] = {r_tag, r_wdata};
                    end
                end
            end else begin
                new_row[AGE_WIDTH +: DW] = r_wdata;
            end
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            sweep_row[w*ENTRY_W +: ENTRY_W] =
                {TAG_W'(0), (i_cmd.sweep_zero ? DW'(0) : r_wdata), AGE_WIDTH'(0)};
        end
    end

    assign ram_we    = i_cmd.sweep_we || (i_cmd.commit && row_we);
    assign ram_waddr = i_cmd.sweep_we ? r_sweep_idx : r_set;
    assign ram_wdata = i_cmd.sweep_we ? sweep_row : new_row;

    sapt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (i_address[SET_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= sapt_pkg::LFSR_SEED;
            r_sweep_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && i_op == sapt_pkg::OP_REPLACE &&
                i_cfg.policy == sapt_pkg::POL_RANDOM) begin
                r_lfsr <= lfsr_next;
            end
            if (i_cmd.sweep_we) begin
                r_sweep_idx <= r_sweep_idx + SET_BITS'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_set   <= i_address[SET_BITS-1:0];
            r_tag   <= i_address[EFF_ADDR-1:SET_BITS];
            r_wdata <= i_entry_data[DW-1:0];
            r_q     <= rcp_prod[PROD_W-1 -: LW];
        end
        if (i_cmd.commit) begin
            r_out_data <= eval_data;
            r_out_hit  <= eval_hit;
        end
    end

    assign o_status.in_fill    = (i_op == sapt_pkg::OP_FILL);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.sweep_last = &r_sweep_idx;

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_hit       = r_out_hit;

`ifndef SYNTHESIS
    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("A result was loaded over one still waiting to be taken.");

    a_sweep_excludes_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep_we && (i_cmd.commit || i_cmd.accept)))
        else $error("The sweep overlapped an item being taken or finished.");

    a_hit_only_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op != sapt_pkg::OP_LOOKUP) |=> (!o_hit && o_data == '0))
        else $error("A non-lookup item produced a hit or non-zero data.");
`endif

endmodule

// ----- hdl/set_assoc_predictor_table.sv -----
// Set-associative predictor table with SETS sets, rounded down to a power of
// two, of WAYS ways; each way holds a tag, a data word and a saturating age.
// The low floor(log2(SETS)) bits of the address select the set and the
// remaining address bits form the tag. A whole set lives in one row of a
// single-port-write, registered-read memory, so a lookup or a replace first
// reads the set's row and then, once the output register is free, compares,
// chooses the way and writes the row back while the result is loaded into
// the output register. A fill writes all 2^floor(log2(SETS)) rows, one a
// cycle. After reset the block clears every row, one a cycle (1024 rows with
// the default set count), and takes no item meanwhile; configuration writes
// are accepted at any time. The block works on one item at a time, and a
// finished result waits in the output register while the next item is taken.
module set_assoc_predictor_table #(
    parameter int SETS       = sapt_pkg::SETS_DEF,
    parameter int WAYS       = sapt_pkg::WAYS_DEF,
    parameter int ADDR_WIDTH = sapt_pkg::ADDR_WIDTH_DEF,
    parameter int DATA_WIDTH = sapt_pkg::DATA_WIDTH_DEF,
    parameter int AGE_WIDTH  = sapt_pkg::AGE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [sapt_pkg::OP_W-1:0]          i_op,
    input  logic [sapt_pkg::ADDR_FIELD_W-1:0]  i_address,
    input  logic [sapt_pkg::DATA_FIELD_W-1:0]  i_entry_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [sapt_pkg::DATA_FIELD_W-1:0]  o_data,
    output logic                               o_hit,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sapt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sapt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sapt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    sapt_pkg::t_cfg       cfg;
    sapt_pkg::t_dp_cmd    dp_cmd;
    sapt_pkg::t_dp_status dp_status;
    logic                 ready;

    sapt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sapt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_ready    (ready)
    );

    sapt_dp #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AGE_WIDTH  (AGE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_cfg        (cfg),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_entry_data (i_entry_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_data       (o_data),
        .o_hit        (o_hit)
    );

    assign o_in_stall = !ready;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sapt_pkg::*;

    localparam int SETS = SETS_DEF;
    localparam int WAYS = WAYS_DEF;
    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int TAG_W = ADDR_FIELD_W - SET_BITS;
    localparam int AGE_W = AGE_WIDTH_DEF;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 30;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        logic [DATA_FIELD_W-1:0] data;
        logic                    hit;
    } t_table_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_op;
    logic [ADDR_FIELD_W-1:0] i_address;
    logic [DATA_FIELD_W-1:0] i_entry_data;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [DATA_FIELD_W-1:0] o_data;
    logic                    o_hit;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [TAG_W-1:0]        shadow_tag  [WAYS][SETS];
    logic [DATA_FIELD_W-1:0] shadow_data [WAYS][SETS];
    logic [AGE_W-1:0]        shadow_age  [WAYS][SETS];
    logic [LFSR_W-1:0]       shadow_lfsr;
    logic [POLICY_W-1:0]     shadow_policy;
    logic                    shadow_tagless;

    t_table_result pending_results[$];
    t_table_result oldest;

    int   error_count = 0;
    int   items_sent = 0;
    int   results_checked = 0;
    int   hits_seen = 0;
    int   configs_written = 0;
    int   op_count [4] = '{0, 0, 0, 0};
    int   burst_left = 0;
    int   cycle_count = 0;
    logic [15:0] stall_tick = '0;
    logic [1:0]  stall_mode = '0;

    set_assoc_predictor_table DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void age_bump(input int w, input int s);
        if (shadow_age[w][s] < AGE_MAX) begin
            shadow_age[w][s] = shadow_age[w][s] + 1'b1;
        end
    endfunction

    function automatic t_table_result predict_table_access(input logic [OP_W-1:0] op,
            input logic [ADDR_FIELD_W-1:0] addr, input logic [DATA_FIELD_W-1:0] value);
        t_table_result    r;
        int               set_idx;
        int               victim;
        logic [TAG_W-1:0] tag;
        logic             found;
        logic             lsb;
        r = '0;
        set_idx = int'(addr[SET_BITS-1:0]);
        tag = addr[ADDR_FIELD_W-1:SET_BITS];
        found = 1'b0;
        victim = 0;
        case (op)
            OP_LOOKUP: begin
                if (shadow_tagless) begin
                    r.data = shadow_data[0][set_idx];
                    r.hit = 1'b1;
                end else begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (!found) begin
                            if (shadow_tag[w][set_idx] == tag) begin
                                if (shadow_policy == POL_LRU) begin
                                    shadow_age[w][set_idx] = '0;
                                end
                                r.data = shadow_data[w][set_idx];
                                r.hit = 1'b1;
                                found = 1'b1;
                            end else if (shadow_policy == POL_LRU) begin
                                age_bump(w, set_idx);
                            end
                        end
                    end
                end
            end
            OP_REPLACE: begin
                if (shadow_policy == POL_LRU) begin
                    for (int w = 1; w < WAYS; w++) begin
                        if (shadow_age[victim][set_idx] < shadow_age[w][set_idx]) begin
                            victim = w;
                        end
                    end
                    shadow_data[victim][set_idx] = value;
                    shadow_tag[victim][set_idx] = tag;
                    shadow_age[victim][set_idx] = '0;
                    for (int w = 0; w < WAYS; w++) begin
                        if (w != victim) begin
                            age_bump(w, set_idx);
                        end
                    end
                end else if (shadow_policy == POL_RANDOM) begin
                    lsb = shadow_lfsr[0];
                    shadow_lfsr = shadow_lfsr >> 1;
                    if (lsb) begin
                        shadow_lfsr = shadow_lfsr ^ LFSR_TAPS;
                    end
                    victim = int'(shadow_lfsr % WAYS);
                    shadow_data[victim][set_idx] = value;
                    shadow_tag[victim][set_idx] = tag;
                end else begin
                    shadow_data[0][set_idx] = value;
                end
            end
            OP_FILL: begin
                for (int w = 0; w < WAYS; w++) begin
                    for (int s = 0; s < SETS; s++) begin
                        shadow_tag[w][s] = '0;
                        shadow_data[w][s] = value;
                        shadow_age[w][s] = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
            input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item outstanding", {o_data, o_hit}, 0);
            end else begin
                oldest = pending_results.pop_front();
                results_checked++;
                if (o_hit === 1'b1) begin
                    hits_seen++;
                end
                if (o_data !== oldest.data) begin
                    report_mismatch("data", o_data, oldest.data);
                end
                if (o_hit !== oldest.hit) begin
                    report_mismatch("hit", o_hit, oldest.hit);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[5:0] == '0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 99) < 40);
            2'd2: i_out_stall <= (stall_tick[2:0] < 3'd3);
            default: i_out_stall <= (stall_tick[4:3] == 2'b11);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_FIELD_W-1:0] addr,
            input logic [DATA_FIELD_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(20, 60);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_address <= addr;
        i_entry_data <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_table_access(op, addr, value));
        items_sent++;
        op_count[op]++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(reg_idx) << CFG_IDX_LSB;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        if (reg_idx == REG_POLICY) begin
            shadow_policy = value[POLICY_W-1:0];
        end else begin
            shadow_tagless = value[0];
        end
        configs_written++;
    endtask

    task automatic set_config(input logic [POLICY_W-1:0] policy, input logic tagless);
        wait_idle();
        write_reg(REG_POLICY, CFG_DATA_W'(policy));
        write_reg(REG_TAGLESS, CFG_DATA_W'(tagless));
    endtask

    function automatic logic [ADDR_FIELD_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
            input int set_idx);
        return {tag, set_idx[SET_BITS-1:0]};
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return TAG_W'(1);
            3: return {TAG_W/2{2'b10}};
            4: return {TAG_W/2{2'b01}};
            5: return TAG_W'(3);
            default: return TAG_W'($urandom);
        endcase
    endfunction

    function automatic int pick_set();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return SETS - 1;
            2: return 1;
            3: return SETS / 2;
            4: return SETS / 2 + 1;
            5: return 7;
            6: return SETS - 2;
            default: return int'($urandom_range(0, SETS - 1));
        endcase
    endfunction

    task automatic test_reset_contents();
        send_item(OP_LOOKUP, '0, 16'h0000);
        send_item(OP_LOOKUP, '1, 16'hFFFF);
        send_item(OP_LOOKUP, make_addr('0, SETS - 1), 16'h5A5A);
        send_item(OP_LOOKUP, make_addr('1, 0), 16'h0000);
    endtask

    task automatic test_each_operation();
        send_item(OP_REPLACE, make_addr('1, 5), 16'hFFFF);
        send_item(OP_LOOKUP, make_addr('0, 5), 16'h0000);
        send_item(OP_UNUSED, '1, 16'hFFFF);
        send_item(OP_FILL, '1, 16'hA5A5);
        send_item(OP_LOOKUP, make_addr(TAG_W'(1), 0), 16'h0000);
        send_item(OP_LOOKUP, make_addr('0, SETS - 1), 16'h0000);
    endtask

    task automatic test_policies();
        set_config(POL_LRU, 1'b0);
        send_item(OP_REPLACE, '1, 16'h1234);
        send_item(OP_LOOKUP, '1, 16'h0000);
        send_item(OP_REPLACE, make_addr(TAG_W'(2), SETS - 1), 16'h0001);
        send_item(OP_LOOKUP, make_addr(TAG_W'(2), SETS - 1), 16'hFFFF);
        set_config(POL_RANDOM, 1'b0);
        for (int k = 1; k <= 3; k++) begin
            send_item(OP_REPLACE, make_addr(TAG_W'(k + 8), 3), 16'(k * 16'h1111));
        end
        for (int k = 1; k <= 3; k++) begin
            send_item(OP_LOOKUP, make_addr(TAG_W'(k + 8), 3), 16'h0000);
        end
        set_config(POL_WAY0, 1'b1);
        send_item(OP_LOOKUP, '1, 16'h0000);
        send_item(OP_LOOKUP, make_addr('1, 3), 16'h0000);
        set_config(POL_SPARE, 1'b0);
        send_item(OP_REPLACE, make_addr(TAG_W'(9), 3), 16'h0000);
        send_item(OP_LOOKUP, make_addr(TAG_W'(9), 3), 16'h0000);
    endtask

    // Distinct ages in one set, then enough misses to pin every way at the
    // ceiling; the next victim is then way 0 rather than the oldest by count.
    task automatic test_age_saturation();
        int s;
        s = SETS - 247;
        set_config(POL_LRU, 1'b0);
        send_item(OP_FILL, '0, 16'h0F0F);
        for (int k = 1; k <= 3; k++) begin
            send_item(OP_REPLACE, make_addr(TAG_W'(16 + k), s), 16'(k * 16'h1010));
        end
        repeat (300) send_item(OP_LOOKUP, make_addr({TAG_W/2{2'b11}}, s), 16'($urandom));
        send_item(OP_REPLACE, make_addr(TAG_W'(20), s), 16'h4444);
        for (int k = 1; k <= 4; k++) begin
            send_item(OP_LOOKUP, make_addr(TAG_W'(16 + k), s), 16'h0000);
        end
        send_item(OP_LOOKUP, make_addr('0, s), 16'h0000);
    endtask

    task automatic test_random_phases();
        logic [POLICY_W-1:0] pol_seq [8] = '{POL_LRU, POL_RANDOM, POL_WAY0, POL_SPARE,
                                             POL_LRU, POL_RANDOM, POL_WAY0, POL_LRU};
        logic                tagless_seq [8] = '{1'b0, 1'b0, 1'b0, 1'b0,
                                                 1'b1, 1'b1, 1'b1, 1'b0};
        logic [OP_W-1:0]         op;
        logic [ADDR_FIELD_W-1:0] addr;
        int                      pick;
        for (int p = 0; p < 8; p++) begin
            set_config(pol_seq[p], tagless_seq[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 999);
                if (pick < 560) begin
                    op = OP_LOOKUP;
                end else if (pick < 955) begin
                    op = OP_REPLACE;
                end else if (pick < 992) begin
                    op = OP_UNUSED;
                end else begin
                    op = OP_FILL;
                end
                if ($urandom_range(0, 99) < 88) begin
                    addr = make_addr(pick_tag(), pick_set());
                end else begin
                    addr = $urandom;
                end
                send_item(op, addr, 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_LOOKUP;
        i_address <= '0;
        i_entry_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int w = 0; w < WAYS; w++) begin
            for (int s = 0; s < SETS; s++) begin
                shadow_tag[w][s] = '0;
                shadow_data[w][s] = '0;
                shadow_age[w][s] = '0;
            end
        end
        shadow_lfsr = LFSR_SEED;
        shadow_policy = POL_WAY0;
        shadow_tagless = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_each_operation();
        test_policies();
        test_age_saturation();
        test_random_phases();
        wait_idle();

        $display("Sent %0d items (%0d lookups, %0d replaces, %0d fills, %0d unused op).",
                 items_sent, op_count[OP_LOOKUP], op_count[OP_REPLACE], op_count[OP_FILL],
                 op_count[OP_UNUSED]);
        $display("Checked %0d results, %0d hits, over %0d register writes; %0d mismatches.",
                 results_checked, hits_seen, configs_written, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
